[src/sctcs_pkg.sv]
// shared constants, command codes, sequencer states and table port type
// for the spi channel table command slave; no dependencies
package sctcs_pkg;

    localparam int          CHANNEL_COUNT_DEF = 128;
    localparam int          FRAME_LEN         = 10;
    localparam int          TBL_ADDR_W        = 8;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd2000;
    localparam logic [7:0]  CHAN_RESET        = 8'hFF;

    localparam logic [7:0]  CMD_SET4   = 8'd1;
    localparam logic [7:0]  CMD_READ8  = 8'd2;
    localparam logic [7:0]  CMD_WRITE8 = 8'd3;
    localparam logic [7:0]  CMD_INFO   = 8'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [TBL_ADDR_W-1:0] addr;
        logic [7:0]            wdata;
    } t_tbl_req;

endpackage

[src/spi_channel_table_command_slave.sv]
// A received byte that does not end a frame gives its result in the cycle after acceptance;
// a frame-ending byte gives it after the command sequence: set-four runs EXEC once per pair,
// read-eight EXEC then RD_WAIT per channel, write-eight EXEC per channel, else DONE. A tick gives no result.
// The input is not ready from the frame-ending byte until its result is loaded; one shared
// channel-number adder/compare and the single table port set the per-channel step count.
// Reset (synchronous, active low) clears frame position, idle count and reply bytes, table to 0xFF.
module spi_channel_table_command_slave #(
    parameter int CHANNEL_COUNT = sctcs_pkg::CHANNEL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,    // timeout_ticks
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] tx_byte
    output logic        o_m_axis_tlast    // frame_done
);

    localparam int FL = sctcs_pkg::FRAME_LEN;

    sctcs_pkg::t_state   r_state, n_state;
    logic [3:0]          r_pos, n_pos;
    logic [15:0]         r_idle, n_idle;
    logic [15:0]         r_timeout;
    logic [7:0]          r_req [FL];
    logic [7:0]          n_req [FL];
    logic [7:0]          r_rep [FL];
    logic [7:0]          n_rep [FL];
    logic [7:0]          r_cmd, n_cmd;
    logic [7:0]          r_base, n_base;
    logic [2:0]          r_k, n_k;
    logic [7:0]          r_tx, n_tx;
    logic                r_ok, n_ok;
    logic                r_out_vld, n_out_vld;
    logic [7:0]          r_out_data, n_out_data;
    logic                r_out_last, n_out_last;

    logic                s_acc;
    logic [15:0]         idle_inc;
    logic [7:0]          u_a;
    logic [2:0]          u_off;
    logic [8:0]          u_sum;
    logic                u_ok;
    logic [7:0]          u_idx;
    sctcs_pkg::t_tbl_req tbl_req;
    logic [7:0]          tbl_rdata;

    sctcs_chan_tbl #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_tbl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (tbl_req),
        .o_rdata(tbl_rdata)
    );

    assign o_s_axis_tready = (r_state == sctcs_pkg::ST_IDLE) && (!r_out_vld || i_m_axis_tready);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    assign idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;

    // shared channel-number unit: set-four takes the number from the request head,
    // the block commands add the step count to the start address
    assign u_a   = (r_cmd == sctcs_pkg::CMD_SET4) ? r_req[1] : r_base;
    assign u_off = (r_cmd == sctcs_pkg::CMD_SET4) ? 3'd0 : r_k;
    assign u_sum = {1'b0, u_a} + {6'b0, u_off};
    assign u_ok  = (u_sum != 9'd0) && (u_sum <= 9'(CHANNEL_COUNT));
    assign u_idx = 8'(u_sum - 9'd1);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_idle     = r_idle;
        n_req      = r_req;
        n_rep      = r_rep;
        n_cmd      = r_cmd;
        n_base     = r_base;
        n_k        = r_k;
        n_tx       = r_tx;
        n_ok       = r_ok;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        tbl_req    = '0;
        tbl_req.addr = u_idx;

        case (r_state)
            sctcs_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser) begin
                        if (idle_inc > r_timeout) begin
                            n_pos  = '0;
                            n_idle = '0;
                        end else begin
                            n_idle = idle_inc;
                        end
                    end else begin
                        n_req[r_pos] = i_s_axis_tdata;
                        n_idle       = '0;
                        if (r_pos == 4'(FL - 1)) begin
                            n_pos  = '0;
                            n_cmd  = r_req[0];
                            n_base = r_req[1];
                            n_k    = '0;
                            case (r_req[0])
                                sctcs_pkg::CMD_SET4: begin
                                    n_tx    = sctcs_pkg::CMD_SET4;
                                    n_state = sctcs_pkg::ST_EXEC;
                                end
                                sctcs_pkg::CMD_READ8, sctcs_pkg::CMD_WRITE8: begin
                                    n_tx     = r_req[0];
                                    n_rep[0] = r_req[1];
                                    n_state  = sctcs_pkg::ST_EXEC;
                                end
                                sctcs_pkg::CMD_INFO: begin
                                    n_tx = sctcs_pkg::CMD_INFO;
                                    for (int i = 1; i < FL; i++) begin
                                        n_rep[i] = '0;
                                    end
                                    n_rep[0] = 8'(CHANNEL_COUNT);
                                    n_state  = sctcs_pkg::ST_DONE;
                                end
                                default: begin
                                    // unknown command leaves the reply as it was
                                    n_tx    = r_rep[FL-1];
                                    n_state = sctcs_pkg::ST_DONE;
                                end
                            endcase
                        end else begin
                            n_pos      = r_pos + 4'd1;
                            n_out_vld  = 1'b1;
                            n_out_data = r_rep[r_pos];
                            n_out_last = 1'b0;
                        end
                    end
                end
            end
            sctcs_pkg::ST_EXEC: begin
                case (r_cmd)
                    sctcs_pkg::CMD_SET4: begin
                        if (u_ok) begin
                            tbl_req.we    = 1'b1;
                            tbl_req.wdata = r_req[2];
                            n_rep[{1'b0, r_k[1:0], 1'b0}] = r_req[1];
                            n_rep[{1'b0, r_k[1:0], 1'b1}] = r_req[2];
                        end else begin
                            n_rep[{1'b0, r_k[1:0], 1'b0}] = sctcs_pkg::CHAN_RESET;
                            n_rep[{1'b0, r_k[1:0], 1'b1}] = '0;
                        end
                        // request bytes slide down so the next pair sits at the head
                        for (int i = 0; i < FL - 2; i++) begin
                            n_req[i] = r_req[i+2];
                        end
                        if (r_k == 3'd3) begin
                            n_state = sctcs_pkg::ST_DONE;
                        end else begin
                            n_k = r_k + 3'd1;
                        end
                    end
                    sctcs_pkg::CMD_READ8: begin
                        tbl_req.re = u_ok;
                        n_ok       = u_ok;
                        n_state    = sctcs_pkg::ST_RD_WAIT;
                    end
                    sctcs_pkg::CMD_WRITE8: begin
                        if (u_ok) begin
                            tbl_req.we    = 1'b1;
                            tbl_req.wdata = r_req[2];
                            n_rep[{1'b0, r_k} + 4'd1] = r_req[2];
                        end else begin
                            n_rep[{1'b0, r_k} + 4'd1] = '0;
                        end
                        for (int i = 0; i < FL - 1; i++) begin
                            n_req[i] = r_req[i+1];
                        end
                        if (r_k == 3'd7) begin
                            n_state = sctcs_pkg::ST_DONE;
                        end else begin
                            n_k = r_k + 3'd1;
                        end
                    end
                    default: begin
                        n_state = sctcs_pkg::ST_DONE;
                    end
                endcase
            end
            sctcs_pkg::ST_RD_WAIT: begin
                n_rep[{1'b0, r_k} + 4'd1] = r_ok ? tbl_rdata : 8'd0;
                if (r_k == 3'd7) begin
                    n_state = sctcs_pkg::ST_DONE;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = sctcs_pkg::ST_EXEC;
                end
            end
            sctcs_pkg::ST_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = r_tx;
                    n_out_last = 1'b1;
                    n_state    = sctcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sctcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sctcs_pkg::ST_IDLE;
            r_pos     <= '0;
            r_idle    <= '0;
            r_timeout <= sctcs_pkg::TIMEOUT_RESET;
            r_k       <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < FL; i++) begin
                r_rep[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_idle    <= n_idle;
            r_k       <= n_k;
            r_out_vld <= n_out_vld;
            r_rep     <= n_rep;
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cmd      <= n_cmd;
        r_base     <= n_base;
        r_tx       <= n_tx;
        r_ok       <= n_ok;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 4'(FL - 1))
        else $error("frame position beyond frame length");

    a_tbl_wr_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_req.we |-> (r_state == sctcs_pkg::ST_EXEC))
        else $error("table written outside command execution");

    a_done_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_pos == 4'd0))
        else $error("frame completion shown while a frame is partly received");

    a_exec_from_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sctcs_pkg::ST_IDLE && n_state == sctcs_pkg::ST_EXEC) |=> (r_pos == 4'd0))
        else $error("command started without frame position returning to zero");

    a_set4_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sctcs_pkg::ST_EXEC && r_cmd == sctcs_pkg::CMD_SET4) |-> (r_k <= 3'd3))
        else $error("set-four step count overrun");

endmodule

[src/sctcs_chan_tbl.sv]
// channel table memory: one write and one registered read per cycle
// per-entry valid bits make unwritten entries read as the reset value; uses sctcs_pkg
module sctcs_chan_tbl #(
    parameter int CHANNEL_COUNT = sctcs_pkg::CHANNEL_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sctcs_pkg::t_tbl_req i_req,
    output logic [7:0]          o_rdata
);

    localparam int IDX_W = $clog2(CHANNEL_COUNT);

    logic [7:0]             r_mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] r_vld;
    logic [7:0]             r_rd_data;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       idx;

    assign idx = i_req.addr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[idx] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[idx] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_vld <= r_vld[idx];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : sctcs_pkg::CHAN_RESET;

endmodule
